/* src/tcp_segment_auto_responder_macros.svh */
`ifndef TCP_SEGMENT_AUTO_RESPONDER_MACROS_SVH
`define TCP_SEGMENT_AUTO_RESPONDER_MACROS_SVH

// checked only out of reset
`define TSAR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TSAR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/tsar_pkg.sv */
`default_nettype none
package tsar_pkg;

  localparam int unsigned MAX_PACKET_BYTES_DEF = 2048;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned REPLY_BYTES = 40;

  localparam logic [15:0] WINDOW_RESET = 16'd5000;
  localparam logic [31:0] ISN_RESET = 32'd123456;

  localparam logic [7:0] FLAG_ACK = 8'h10;
  localparam logic [7:0] FLAG_SYNACK = 8'h12;
  localparam logic [7:0] FLAG_FINACK = 8'h11;
  localparam logic [7:0] PROTO_TCP = 8'd6;

  typedef enum logic [1:0] {
    REG_PASSIVE = 2'd0,
    REG_WINDOW = 2'd1,
    REG_ISN = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SUM,
    BK_FOLD,
    BK_SEND
  } back_state_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic in_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic out_last;
  } out_beat_t;

  typedef struct packed {
    logic passive_mode;
    logic [15:0] reply_window;
    logic [31:0] initial_sequence;
  } cfg_t;

  typedef logic [19:0][7:0] hdr_t;

  typedef struct packed {
    logic [7:0] tos;
    logic [15:0] ident;
    logic [15:0] frag;
    logic [7:0] ttl;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] ack;
    logic [7:0] flags;
    logic seq_inc;
  } desc_t;

  typedef struct packed {
    logic [1:0] count;
    logic full;
  } queue_stat_t;

  typedef struct packed {
    logic snap_valid;
  } front_stat_t;

endpackage
`default_nettype wire

/* src/tsar_front.sv */
`default_nettype none
module tsar_front #(
  parameter int unsigned MaxBytes = 2048
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  input  wire tsar_pkg::in_beat_t in_beat_i,
  input  wire logic passive_i,
  output logic push_o,
  output tsar_pkg::desc_t desc_o,
  input  wire logic full_i,
  output tsar_pkg::front_stat_t stat_o
);
  import tsar_pkg::*;

  localparam int unsigned CW = $clog2(MaxBytes + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  hdr_t hdr_q, hdr_d;
  logic [20:0] sum_q, sum_d;
  logic [15:0] sp_q, sp_d, dp_q, dp_d;
  logic [31:0] seq_q, seq_d;
  logic [3:0] doff_q, doff_d;
  logic [1:0] sf_q, sf_d;
  logic bad_q, bad_d;
  logic [5:0] hl;
  logic [CW-1:0] t;

  logic snap_v_q;
  logic [CW-1:0] s_cnt_q;
  hdr_t s_hdr_q;
  logic [20:0] s_sum_q;
  logic [15:0] s_sp_q, s_dp_q;
  logic [31:0] s_seq_q;
  logic [3:0] s_doff_q;
  logic [1:0] s_sf_q;
  logic s_bad_q;

  logic acc, done, want, ok;
  logic [5:0] s_hl, doff4;
  logic [16:0] f1;
  logic [15:0] f2;
  logic [CW-1:0] seg, payload;
  logic [7:0] b;

  assign b = in_beat_i.in_byte;
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    cnt_d = cnt_q;
    hdr_d = hdr_q;
    sum_d = sum_q;
    sp_d = sp_q;
    dp_d = dp_q;
    seq_d = seq_q;
    doff_d = doff_q;
    sf_d = sf_q;
    bad_d = bad_q;
    hl = '0;
    t = '0;
    if (cnt_q >= CW'(MaxBytes)) begin
      bad_d = 1'b1;
    end else begin
      hl = (cnt_q == '0) ? {b[3:0], 2'b00} : {hdr_q[0][3:0], 2'b00};
      if (cnt_q < CW'(20)) hdr_d[cnt_q[4:0]] = b;
      if (cnt_q < CW'(hl)) begin
        sum_d = sum_q + (cnt_q[0] ? {13'b0, b} : {5'b0, b, 8'b0});
      end
      if (hl >= 6'd20 && cnt_q >= CW'(hl)) begin
        t = cnt_q - CW'(hl);
        if (t < CW'(2)) sp_d = {sp_q[7:0], b};
        else if (t < CW'(4)) dp_d = {dp_q[7:0], b};
        else if (t < CW'(8)) seq_d = {seq_q[23:0], b};
        else if (t == CW'(12)) doff_d = b[7:4];
        else if (t == CW'(13)) sf_d = b[1:0];
      end
      cnt_d = cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
      doff_q <= '0;
      sf_q <= '0;
      bad_q <= 1'b0;
    end else if (acc) begin
      if (in_beat_i.in_last) begin
        cnt_q <= '0;
        sum_q <= '0;
        doff_q <= '0;
        sf_q <= '0;
        bad_q <= 1'b0;
      end else begin
        cnt_q <= cnt_d;
        sum_q <= sum_d;
        doff_q <= doff_d;
        sf_q <= sf_d;
        bad_q <= bad_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      hdr_q <= hdr_d;
      sp_q <= sp_d;
      dp_q <= dp_d;
      seq_q <= seq_d;
    end
    if (acc && in_beat_i.in_last) begin
      s_cnt_q <= cnt_d;
      s_hdr_q <= hdr_d;
      s_sum_q <= sum_d;
      s_sp_q <= sp_d;
      s_dp_q <= dp_d;
      s_seq_q <= seq_d;
      s_doff_q <= doff_d;
      s_sf_q <= sf_d;
      s_bad_q <= bad_d;
    end
  end

  always_comb begin
    s_hl = {s_hdr_q[0][3:0], 2'b00};
    doff4 = {s_doff_q, 2'b00};
    f1 = {1'b0, s_sum_q[15:0]} + {12'b0, s_sum_q[20:16]};
    f2 = f1[15:0] + {15'b0, f1[16]};
    seg = s_cnt_q - CW'(s_hl);
    payload = seg - CW'(doff4);
    ok = !s_bad_q && s_cnt_q >= CW'(20) && s_hdr_q[0][7:4] == 4'd4 &&
         s_hl >= 6'd20 && CW'(s_hl) <= s_cnt_q &&
         {s_hdr_q[2], s_hdr_q[3]} == 16'(s_cnt_q) && f2 == 16'hFFFF &&
         s_hdr_q[9] == PROTO_TCP && seg >= CW'(20) && seg >= CW'(doff4);
    desc_o.tos = s_hdr_q[1];
    desc_o.ident = {s_hdr_q[4], s_hdr_q[5]};
    desc_o.frag = {s_hdr_q[6], s_hdr_q[7]};
    desc_o.ttl = s_hdr_q[8];
    desc_o.src_addr = {s_hdr_q[16], s_hdr_q[17], s_hdr_q[18], s_hdr_q[19]};
    desc_o.dst_addr = {s_hdr_q[12], s_hdr_q[13], s_hdr_q[14], s_hdr_q[15]};
    desc_o.src_port = s_dp_q;
    desc_o.dst_port = s_sp_q;
    desc_o.ack = s_seq_q + 32'd1;
    desc_o.flags = FLAG_ACK;
    desc_o.seq_inc = 1'b1;
    want = ok;
    if (s_sf_q[1]) begin
      desc_o.flags = passive_i ? FLAG_SYNACK : FLAG_ACK;
      desc_o.seq_inc = !passive_i;
    end else if (s_sf_q[0]) begin
      desc_o.flags = FLAG_FINACK;
    end else if (payload != '0) begin
      desc_o.ack = s_seq_q + 32'(payload);
    end else begin
      want = 1'b0;
    end
  end

  assign done = snap_v_q && (!want || !full_i);
  assign push_o = snap_v_q && want && !full_i;
  assign in_ready_o = !snap_v_q || done;
  assign stat_o.snap_valid = snap_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_v_q <= 1'b0;
    end else if (acc && in_beat_i.in_last) begin
      snap_v_q <= 1'b1;
    end else if (done) begin
      snap_v_q <= 1'b0;
    end
  end
endmodule
`default_nettype wire

/* src/tsar_queue.sv */
`default_nettype none
module tsar_queue (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire tsar_pkg::desc_t desc_i,
  input  wire logic pop_i,
  output logic valid_o,
  output tsar_pkg::desc_t desc_o,
  output tsar_pkg::queue_stat_t stat_o
);
  import tsar_pkg::*;

  desc_t mem_q [QUEUE_DEPTH];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  assign valid_o = cnt_q != 2'd0;
  assign desc_o = mem_q[rp_q];
  assign stat_o.count = cnt_q;
  assign stat_o.full = cnt_q == 2'(QUEUE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= desc_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule
`default_nettype wire

/* src/tsar_back.sv */
`default_nettype none
module tsar_back (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_valid_i,
  input  wire tsar_pkg::desc_t desc_i,
  output logic pop_o,
  input  wire tsar_pkg::cfg_t cfg_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output tsar_pkg::out_beat_t out_beat_o
);
  import tsar_pkg::*;

  back_state_e state_q, state_d;
  desc_t w_q;
  logic [5:0] cnt_q, cnt_d;
  logic [19:0] ip_raw_q, tcp_raw_q;
  logic [15:0] ip_ck_q, tcp_ck_q;
  logic [31:0] seq;
  logic [19:0] ip_raw, tcp_raw;
  logic [16:0] ip_f1, tcp_f1;
  logic [15:0] ip_f2, tcp_f2;
  logic [7:0] rb [REPLY_BYTES];
  logic load;

  assign seq = cfg_i.initial_sequence + {31'b0, w_q.seq_inc};

  always_comb begin
    ip_raw = {4'b0, 8'h45, w_q.tos} + 20'd40 + {4'b0, w_q.ident} + {4'b0, w_q.frag} +
             {4'b0, w_q.ttl, PROTO_TCP} + {4'b0, w_q.src_addr[31:16]} +
             {4'b0, w_q.src_addr[15:0]} + {4'b0, w_q.dst_addr[31:16]} +
             {4'b0, w_q.dst_addr[15:0]};
    tcp_raw = {4'b0, w_q.src_addr[31:16]} + {4'b0, w_q.src_addr[15:0]} +
              {4'b0, w_q.dst_addr[31:16]} + {4'b0, w_q.dst_addr[15:0]} +
              {4'b0, w_q.src_port} + {4'b0, w_q.dst_port} +
              {4'b0, seq[31:16]} + {4'b0, seq[15:0]} +
              {4'b0, w_q.ack[31:16]} + {4'b0, w_q.ack[15:0]} +
              {4'b0, 8'h50, w_q.flags} + {4'b0, cfg_i.reply_window} + 20'd26;
    ip_f1 = {1'b0, ip_raw_q[15:0]} + {13'b0, ip_raw_q[19:16]};
    ip_f2 = ip_f1[15:0] + {15'b0, ip_f1[16]};
    tcp_f1 = {1'b0, tcp_raw_q[15:0]} + {13'b0, tcp_raw_q[19:16]};
    tcp_f2 = tcp_f1[15:0] + {15'b0, tcp_f1[16]};
  end

  always_comb begin
    rb[0] = 8'h45;
    rb[1] = w_q.tos;
    rb[2] = 8'd0;
    rb[3] = 8'd40;
    rb[4] = w_q.ident[15:8];
    rb[5] = w_q.ident[7:0];
    rb[6] = w_q.frag[15:8];
    rb[7] = w_q.frag[7:0];
    rb[8] = w_q.ttl;
    rb[9] = PROTO_TCP;
    rb[10] = ip_ck_q[15:8];
    rb[11] = ip_ck_q[7:0];
    for (int k = 0; k < 4; k++) begin
      rb[12 + k] = w_q.src_addr[31 - 8 * k -: 8];
      rb[16 + k] = w_q.dst_addr[31 - 8 * k -: 8];
      rb[24 + k] = seq[31 - 8 * k -: 8];
      rb[28 + k] = w_q.ack[31 - 8 * k -: 8];
    end
    rb[20] = w_q.src_port[15:8];
    rb[21] = w_q.src_port[7:0];
    rb[22] = w_q.dst_port[15:8];
    rb[23] = w_q.dst_port[7:0];
    rb[32] = 8'h50;
    rb[33] = w_q.flags;
    rb[34] = cfg_i.reply_window[15:8];
    rb[35] = cfg_i.reply_window[7:0];
    rb[36] = tcp_ck_q[15:8];
    rb[37] = tcp_ck_q[7:0];
    rb[38] = 8'd0;
    rb[39] = 8'd0;
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    load = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          load = 1'b1;
          state_d = BK_SUM;
        end
      end
      BK_SUM: state_d = BK_FOLD;
      BK_FOLD: begin
        cnt_d = '0;
        state_d = BK_SEND;
      end
      BK_SEND: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (cnt_q == 6'(REPLY_BYTES - 1)) state_d = BK_IDLE;
          else cnt_d = cnt_q + 6'd1;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  assign pop_o = load;
  assign out_beat_o.out_byte = rb[cnt_q];
  assign out_beat_o.out_last = cnt_q == 6'(REPLY_BYTES - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) w_q <= desc_i;
    if (state_q == BK_SUM) begin
      ip_raw_q <= ip_raw;
      tcp_raw_q <= tcp_raw;
    end
    if (state_q == BK_FOLD) begin
      ip_ck_q <= ~ip_f2;
      tcp_ck_q <= ~tcp_f2;
    end
  end
endmodule
`default_nettype wire

/* src/tcp_segment_auto_responder.sv */
// Takes an IPv4 packet one byte per beat and answers acceptable TCP segments
// with a 40-byte IPv4+TCP reply. Input runs at one byte per cycle; it stalls
// only while a finished packet waits for room in the two-entry reply queue.
// Each reply is loaded and checksummed in BK_IDLE, BK_SUM and BK_FOLD, then
// sent as 40 beats before the next is taken. Replies leave in packet order.
`default_nettype none
`include "tcp_segment_auto_responder_macros.svh"
module tcp_segment_auto_responder #(
  parameter int unsigned MAX_PACKET_BYTES = tsar_pkg::MAX_PACKET_BYTES_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  input  wire tsar_pkg::in_beat_t in_beat_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output tsar_pkg::out_beat_t out_beat_o,
  input  wire logic cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i
);
  import tsar_pkg::*;

  cfg_t cfg_q;
  logic push, pop, q_valid;
  desc_t f_desc, q_desc;
  queue_stat_t q_stat;
  front_stat_t f_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.passive_mode <= 1'b1;
      cfg_q.reply_window <= WINDOW_RESET;
      cfg_q.initial_sequence <= ISN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PASSIVE: cfg_q.passive_mode <= cfg_wdata_i[0];
        REG_WINDOW: cfg_q.reply_window <= cfg_wdata_i[15:0];
        REG_ISN: cfg_q.initial_sequence <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  tsar_front #(.MaxBytes(MAX_PACKET_BYTES)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_beat_i,
    .passive_i(cfg_q.passive_mode), .push_o(push), .desc_o(f_desc),
    .full_i(q_stat.full), .stat_o(f_stat)
  );

  tsar_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .desc_i(f_desc), .pop_i(pop),
    .valid_o(q_valid), .desc_o(q_desc), .stat_o(q_stat)
  );

  tsar_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .desc_i(q_desc), .pop_o(pop),
    .cfg_i(cfg_q), .out_valid_o, .out_ready_i, .out_beat_o
  );

  `TSAR_ASSERT_ALWAYS(a_q_bound, clk_i, q_stat.count <= 2'(QUEUE_DEPTH), "queue overfilled")
  `TSAR_ASSERT(a_no_push_full, clk_i, rst_ni, push |-> !q_stat.full, "push into full queue")
  `TSAR_ASSERT(a_stall_cause, clk_i, rst_ni, !in_ready_o |-> f_stat.snap_valid && q_stat.full,
               "input stalled without a waiting packet")
  `TSAR_ASSERT(a_pop_valid, clk_i, rst_ni, pop |-> q_valid, "pop from empty queue")
endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
module tb;
  import tsar_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_beat_t in_beat_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_beat_t out_beat_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;

  tcp_segment_auto_responder i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_beat_i(in_beat_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_beat_o(out_beat_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  in_beat_t pending_beats[$];
  out_beat_t reply_bytes[$];
  int errors = 0;
  int cycles = 0;
  int replies = 0;
  int packets = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_send = 1'b0;
  bit in_taken = 1'b0;

  logic m_passive;
  logic [15:0] m_window;
  logic [31:0] m_isn;
  int unsigned m_count;
  logic [7:0] m_hdr[20];
  logic [31:0] m_ipsum;
  logic [15:0] m_sport, m_dport;
  logic [31:0] m_seq;
  logic [3:0] m_doff;
  logic [1:0] m_synfin;
  logic m_bad;

  function automatic logic [15:0] fold_sum(logic [31:0] s);
    while (s >> 16) s = (s & 32'hFFFF) + (s >> 16);
    return s[15:0];
  endfunction

  task automatic clear_packet();
    m_count = 0;
    foreach (m_hdr[k]) m_hdr[k] = '0;
    m_ipsum = 0; m_sport = 0; m_dport = 0; m_seq = 0; m_doff = 0;
    m_synfin = 0; m_bad = 0;
  endtask

  task automatic build_reply();
    logic [7:0] r[40];
    logic [31:0] hl, seg, pay, seq, ack, s;
    logic [7:0] fl;
    int unsigned n;
    n = m_count;
    if (m_bad || n < 20) return;
    if (m_hdr[0][7:4] != 4) return;
    hl = m_hdr[0][3:0] * 4;
    if (hl < 20 || hl > n) return;
    if ({m_hdr[2], m_hdr[3]} != n[15:0] || n > 65535) return;
    if (fold_sum(m_ipsum) != 16'hFFFF) return;
    if (m_hdr[9] != PROTO_TCP) return;
    seg = n - hl;
    if (seg < 20 || seg < m_doff * 4) return;
    pay = seg - m_doff * 4;
    if (m_synfin[1]) begin
      seq = m_passive ? m_isn : m_isn + 1;
      ack = m_seq + 1;
      fl = m_passive ? FLAG_SYNACK : FLAG_ACK;
    end else if (m_synfin[0]) begin
      seq = m_isn + 1; ack = m_seq + 1; fl = FLAG_FINACK;
    end else if (pay > 0) begin
      seq = m_isn + 1; ack = m_seq + pay; fl = FLAG_ACK;
    end else begin
      return;
    end
    for (int k = 0; k < 20; k++) r[k] = m_hdr[k];
    r[0] = 8'h45; r[2] = 0; r[3] = 40; r[10] = 0; r[11] = 0;
    for (int k = 0; k < 4; k++) begin
      r[12 + k] = m_hdr[16 + k];
      r[16 + k] = m_hdr[12 + k];
    end
    s = 0;
    for (int k = 0; k < 20; k += 2) s += {r[k], r[k + 1]};
    s = ~fold_sum(s);
    r[10] = s[15:8]; r[11] = s[7:0];
    {r[20], r[21]} = m_dport;
    {r[22], r[23]} = m_sport;
    {r[24], r[25], r[26], r[27]} = seq;
    {r[28], r[29], r[30], r[31]} = ack;
    r[32] = 8'h50; r[33] = fl;
    {r[34], r[35]} = m_window;
    r[36] = 0; r[37] = 0; r[38] = 0; r[39] = 0;
    s = 26;
    for (int k = 12; k < 40; k += 2) s += {r[k], r[k + 1]};
    s = ~fold_sum(s);
    r[36] = s[15:8]; r[37] = s[7:0];
    for (int k = 0; k < 40; k++) reply_bytes.push_back('{out_byte: r[k], out_last: k == 39});
  endtask

  task automatic predict_beat(in_beat_t bt);
    int unsigned i, hl, t;
    logic [7:0] b;
    b = bt.in_byte;
    if (m_count >= MAX_PACKET_BYTES_DEF) begin
      m_bad = 1;
    end else begin
      i = m_count;
      hl = (i == 0) ? b[3:0] * 4 : m_hdr[0][3:0] * 4;
      if (i < 20) m_hdr[i] = b;
      if (i < hl) m_ipsum += i[0] ? b : (b << 8);
      if (hl >= 20 && i >= hl) begin
        t = i - hl;
        if (t < 2) m_sport = {m_sport[7:0], b};
        else if (t < 4) m_dport = {m_dport[7:0], b};
        else if (t < 8) m_seq = {m_seq[23:0], b};
        else if (t == 12) m_doff = b[7:4];
        else if (t == 13) m_synfin = b[1:0];
      end
      m_count = i + 1;
    end
    if (bt.in_last) begin
      packets++;
      build_reply();
      clear_packet();
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0h expected %0h", what, got, want);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (pending_beats.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          in_beat_i <= pending_beats.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) predict_beat(in_beat_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (reply_bytes.size() == 0) begin
        report_mismatch("unexpected beat", out_beat_o, 0);
      end else begin
        out_beat_t w;
        w = reply_bytes.pop_front();
        if (out_beat_o.out_byte !== w.out_byte)
          report_mismatch("out_byte", out_beat_o.out_byte, w.out_byte);
        if (out_beat_o.out_last !== w.out_last)
          report_mismatch("out_last", out_beat_o.out_last, w.out_last);
        if (w.out_last) replies++;
      end
    end
    if (cycles > 2000000) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [31:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_PASSIVE: m_passive = v[0];
      REG_WINDOW: m_window = v[15:0];
      default: m_isn = v;
    endcase
  endtask

  task automatic drain();
    while (pending_beats.size() > 0 || in_valid_i || reply_bytes.size() > 0)
      @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  // kind: 0 SYN, 1 FIN, 2 or 3 no SYN/FIN (rarely both set); mangle: 0 none, 1 bad sum,
  // 2 bad len, 3 not TCP, 4 bad version, 5 short segment
  task automatic queue_packet(int kind, int opts, int pay, int mangle, int doff);
    logic [7:0] p[$];
    logic [31:0] s;
    int hl, n;
    hl = 20 + 4 * opts;
    n = hl + 20 + pay;
    if (mangle == 5) n = hl + $urandom_range(19);
    p.delete();
    for (int k = 0; k < n; k++) p.push_back(8'($urandom));
    p[0] = {4'd4, 4'(hl / 4)};
    if (mangle == 4) p[0][7:4] = $urandom_range(15) == 4 ? 4'd5 : 4'($urandom_range(15));
    if (mangle == 4 && p[0][7:4] == 4) p[0][7:4] = 4'd6;
    {p[2], p[3]} = 16'(n);
    if (mangle == 2) {p[2], p[3]} = 16'(n + $urandom_range(1, 3));
    p[9] = mangle == 3 ? 8'd17 : PROTO_TCP;
    p[10] = 0; p[11] = 0;
    s = 0;
    for (int k = 0; k < hl; k += 2) s += {p[k], p[k + 1]};
    s = ~fold_sum(s);
    {p[10], p[11]} = s[15:0];
    if (mangle == 1) p[11] = p[11] ^ 8'h01;
    if (n > hl + 13) begin
      p[hl + 12] = {4'(doff), p[hl + 12][3:0]};
      p[hl + 13] = {p[hl + 13][7:2], kind == 0 ? 2'b10 : kind == 1 ? 2'b01 :
                    ($urandom_range(9) == 0 ? 2'b11 : 2'b00)};
    end
    for (int k = 0; k < n; k++) pending_beats.push_back('{in_byte: p[k], in_last: k == n - 1});
  endtask

  task automatic queue_noise(int n);
    for (int k = 0; k < n; k++)
      pending_beats.push_back('{in_byte: 8'($urandom), in_last: k == n - 1});
  endtask

  task automatic random_packets(int count);
    int r, m;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      m = r < 70 ? 0 : $urandom_range(1, 5);
      if (r >= 95) queue_noise($urandom_range(1, 30));
      else queue_packet($urandom_range(3), $urandom_range(9) == 0 ? $urandom_range(1, 10) : 0,
                        $urandom_range(9) == 0 ? $urandom_range(0, 60) : $urandom_range(0, 6),
                        m, $urandom_range(19) == 0 ? $urandom_range(15) : 5);
    end
  endtask

  initial begin
    m_passive = 1; m_window = WINDOW_RESET; m_isn = ISN_RESET;
    clear_packet();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 6; recv_idle_pct = 74;
    queue_packet(0, 0, 0, 0, 5);
    queue_packet(2, 0, 0, 0, 2);
    queue_packet(0, 0, 0, 5, 5);
    queue_noise(1);
    drain();

    write_reg(REG_PASSIVE, 0);
    write_reg(REG_WINDOW, 16'hFFFF);
    write_reg(REG_ISN, 32'hFFFF_FFFF);
    send_idle_pct = 74; recv_idle_pct = 6;
    queue_packet(0, 0, 0, 0, 5);
    queue_packet(1, 0, 0, 0, 5);
    while (pending_beats.size() > 0) @(negedge clk_i);
    hold_send = 1'b1;
    while (in_valid_i || reply_bytes.size() > 0) @(negedge clk_i);
    hold_send = 1'b0;
    queue_packet(0, 0, 0, 1, 5);
    drain();

    write_reg(REG_PASSIVE, 1);
    write_reg(REG_WINDOW, 0);
    write_reg(REG_ISN, 0);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_packets(2);
    drain();

    $display("run covered %0d packets and %0d replies over three register settings",
             packets, replies);
    $display("with slow receiver, slow sender and no idling at all");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
